### src/rpl_pkg.sv
// Package for the position reply line parser.
// Holds the parse phase type, character codes, the keyword table and the result type.
// No dependencies.
package rpl_pkg;

  localparam int LineCapDefault = 64;
  localparam int KwLen          = 5;
  localparam logic [31:0] MagLimit = 32'h8000_0000;
  localparam logic [31:0] PosMax   = 32'h7FFF_FFFF;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpE   = 8'h45;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_BLANKS = 3'd1,
    PH_SIGNED = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4,
    PH_DEAD   = 3'd5
  } phase_e;

  typedef struct packed {
    logic signed [31:0] position;
    logic               position_found;
  } rpl_result_t;

  // Characters of the keyword "EPOS=" by index.
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h45;
      3'd1:    ch = 8'h50;
      3'd2:    ch = 8'h4F;
      3'd3:    ch = 8'h53;
      3'd4:    ch = 8'h3D;
      default: ch = 8'hFF;
    endcase
    return ch;
  endfunction

endpackage

### src/rpl_byte_if.sv
// Byte channel interface for the position reply line parser.
// Carries valid, ready and one received byte. No dependencies.
interface rpl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### src/rpl_result_if.sv
// Result channel interface for the position reply line parser.
// Carries valid, ready, the position and the found flag. No dependencies.
interface rpl_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic               position_found;

  modport source (output valid, output position, output position_found, input ready);
  modport sink   (input valid, input position, input position_found, output ready);
endinterface

### src/rpl_line_core.sv
// Line state and per-byte parsing logic of the position reply line parser.
// Depends on rpl_pkg.
module rpl_line_core #(
  parameter int LINE_CAP = rpl_pkg::LineCapDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output logic                 res_valid_o,
  output rpl_pkg::rpl_result_t res_o
);
  import rpl_pkg::*;

  localparam int CntW = $clog2(LINE_CAP);
  localparam logic [CntW-1:0] CntMax = CntW'(LINE_CAP - 1);

  logic [2:0]      kw_q, kw_d;
  phase_e          phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [31:0]     mag_q, mag_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     held_q, held_d;

  logic        is_digit, is_blank, is_sign, found;
  logic [3:0]  digit_val;
  logic [35:0] mag_ext;
  logic [31:0] mag_next, line_pos;

  assign is_digit  = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_blank  = (byte_i == ChSpace) || (byte_i == ChTab) ||
                     (byte_i == ChVt) || (byte_i == ChFf);
  assign is_sign   = (byte_i == ChPlus) || (byte_i == ChMinus);
  assign digit_val = 4'(byte_i - ChZero);

  // Multiply by ten as two shifts and an add; the magnitude never exceeds 2^31.
  assign mag_ext  = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {32'd0, digit_val};
  assign mag_next = (mag_ext > {4'd0, MagLimit}) ? MagLimit : mag_ext[31:0];

  assign found    = (phase_q == PH_BLANKS) || (phase_q == PH_SIGNED) ||
                    (phase_q == PH_DIGITS) || (phase_q == PH_DONE);
  assign line_pos = neg_q ? (32'd0 - mag_q) : ((mag_q > PosMax) ? PosMax : mag_q);

  assign res_valid_o           = (byte_i == ChLf) && (cnt_q != '0);
  assign res_o.position        = found ? line_pos : held_q;
  assign res_o.position_found  = found;

  always_comb begin
    kw_d    = kw_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    cnt_d   = cnt_q;
    held_d  = held_q;
    if (byte_i == ChLf) begin
      if (res_valid_o && found) begin
        held_d = line_pos;
      end
      kw_d    = '0;
      phase_d = PH_SEARCH;
      neg_d   = 1'b0;
      mag_d   = '0;
      cnt_d   = '0;
    end else if ((byte_i != ChCr) && (cnt_q < CntMax)) begin
      cnt_d = cnt_q + 1'b1;
      unique case (phase_q)
        PH_SEARCH: begin
          if (byte_i == ChNul) begin
            phase_d = PH_DEAD;
          end else if ((kw_q < 3'(KwLen)) && (byte_i == kw_char(kw_q))) begin
            kw_d = kw_q + 1'b1;
            if (kw_q == 3'(KwLen - 1)) begin
              phase_d = PH_BLANKS;
            end
          end else begin
            kw_d = (byte_i == ChUpE) ? 3'd1 : 3'd0;
          end
        end
        PH_BLANKS: begin
          if (is_blank) begin
            phase_d = PH_BLANKS;
          end else if (is_sign) begin
            neg_d   = (byte_i == ChMinus);
            phase_d = PH_SIGNED;
          end else if (is_digit) begin
            mag_d   = mag_next;
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_SIGNED, PH_DIGITS: begin
          if (is_digit) begin
            mag_d   = mag_next;
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_DONE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_q    <= '0;
      phase_q <= PH_SEARCH;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      cnt_q   <= '0;
      held_q  <= '0;
    end else if (step_i) begin
      kw_q    <= kw_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      cnt_q   <= cnt_d;
      held_q  <= held_d;
    end
  end

endmodule

### src/position_reply_line_parser.sv
// Top level of the position reply line parser.
// Depends on rpl_pkg, rpl_byte_if, rpl_result_if and rpl_line_core.
//
// Usage: received serial bytes enter on rx_i, one byte per transaction.
// Carriage returns are dropped; only the first LINE_CAP-1 other bytes of a
// line are examined, and a zero byte hides the rest of the line. The first
// "EPOS=" in a line starts a decimal parse with optional blanks and sign,
// saturating to the 32-bit signed range. A newline ending a non-empty line
// sends one transaction on res_o with the held position and a found flag.
// Throughput: one byte per cycle while no result waits for the output. An
// accepted byte is held in the input register while its line state update
// is computed; when it is processed, the line state and the output register
// are written together, so the result reaches res_o through both registers.
// Stall: a newline that produces a result waits in the input register while
// the output register is still full; other bytes keep flowing. With both
// registers full, rx_i.ready drops until res_o is taken.
// Reset: rst_ni clears the line state, the held position (to zero) and both
// valid flags; no result is pending after reset.
module position_reply_line_parser #(
  parameter int LINE_CAP = rpl_pkg::LineCapDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  rpl_byte_if.sink     rx_i,
  rpl_result_if.source res_o
);
  import rpl_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        out_vld_q;
  rpl_result_t out_q;

  logic        core_res_valid;
  rpl_result_t core_res;
  logic        out_free;
  logic        step;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_vld_q || res_o.ready;
  // A byte in the input register is processed unless it would create a
  // result that has nowhere to go.
  assign step = in_vld_q && (!core_res_valid || out_free);
  assign rx_i.ready = !in_vld_q || step;

  rpl_line_core #(
    .LINE_CAP (LINE_CAP)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step && core_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && core_res_valid) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.position       = out_q.position;
  assign res_o.position_found = out_q.position_found;

endmodule

### bench/rpl_line_checker.sv
// Checker for the position reply line parser.
// Watches the byte and result channels, predicts each line report and compares it.
// Depends on rpl_pkg, rpl_byte_if and rpl_result_if.
module rpl_line_checker #(
  parameter int LINE_CAP = rpl_pkg::LineCapDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rpl_byte_if   rx_mon,
  rpl_result_if res_mon,
  output int    fail_count_o,
  output int    pending_o
);
  import rpl_pkg::*;

  localparam logic [8*KwLen-1:0] KEYWORD_BITS = "EPOS=";

  phase_e             line_phase  = PH_SEARCH;
  logic [2:0]         kw_hits     = '0;
  logic               minus_seen  = 1'b0;
  logic [31:0]        magnitude   = '0;
  int unsigned        line_len    = 0;
  logic signed [31:0] last_pos    = '0;
  rpl_result_t        position_reports_q[$];

  task automatic accumulate_digit(input logic [7:0] ch);
    logic [63:0] wide;
    wide = 64'(magnitude) * 64'd10 + 64'(ch - ChZero);
    if (wide > 64'(MagLimit)) wide = 64'(MagLimit);
    magnitude = wide[31:0];
  endtask

  task automatic scan_line_char(input logic [7:0] ch);
    logic is_digit;
    is_digit = (ch >= ChZero) && (ch <= ChNine);
    case (line_phase)
      PH_SEARCH: begin
        if (ch == ChNul) begin
          line_phase = PH_DEAD;
        end else if (ch == KEYWORD_BITS[8*(KwLen-1-int'(kw_hits)) +: 8]) begin
          kw_hits = kw_hits + 3'd1;
          if (kw_hits == 3'(KwLen)) line_phase = PH_BLANKS;
        end else begin
          kw_hits = (ch == ChUpE) ? 3'd1 : 3'd0;
        end
      end
      PH_BLANKS: begin
        if (ch == ChSpace || ch == ChTab || ch == ChVt || ch == ChFf) begin
          // Leading blanks are skipped.
        end else if (ch == ChPlus || ch == ChMinus) begin
          minus_seen = (ch == ChMinus);
          line_phase = PH_SIGNED;
        end else if (is_digit) begin
          accumulate_digit(ch);
          line_phase = PH_DIGITS;
        end else begin
          line_phase = PH_DONE;
        end
      end
      PH_SIGNED, PH_DIGITS: begin
        if (is_digit) begin
          accumulate_digit(ch);
          line_phase = PH_DIGITS;
        end else begin
          line_phase = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic clear_line_state();
    line_phase = PH_SEARCH;
    kw_hits    = '0;
    minus_seen = 1'b0;
    magnitude  = '0;
    line_len   = 0;
  endtask

  task automatic parse_reply_byte(input logic [7:0] ch);
    rpl_result_t report;
    if (ch == ChCr) return;
    if (ch == ChLf) begin
      if (line_len != 0) begin
        report.position_found = line_phase inside {PH_BLANKS, PH_SIGNED, PH_DIGITS, PH_DONE};
        if (report.position_found) begin
          if (minus_seen) last_pos = 32'd0 - magnitude;
          else last_pos = (magnitude > PosMax) ? PosMax : magnitude;
        end
        report.position = last_pos;
        position_reports_q.push_back(report);
      end
      clear_line_state();
    end else if (line_len < LINE_CAP - 1) begin
      line_len++;
      scan_line_char(ch);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rpl_result_t want;
    if (!rst_ni) begin
      clear_line_state();
      last_pos = '0;
      position_reports_q.delete();
      fail_count_o = 0;
    end else begin
      if (rx_mon.valid && rx_mon.ready) parse_reply_byte(rx_mon.rx_byte);
      if (res_mon.valid && res_mon.ready) begin
        if (position_reports_q.size() == 0) begin
          $display("%0t: unexpected report position %0d found %0b", $time,
                   res_mon.position, res_mon.position_found);
          fail_count_o++;
        end else begin
          want = position_reports_q.pop_front();
          if (res_mon.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time,
                     want.position, res_mon.position);
            fail_count_o++;
          end
          if (res_mon.position_found !== want.position_found) begin
            $display("%0t: position_found expected %0b actual %0b", $time,
                     want.position_found, res_mon.position_found);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = position_reports_q.size();
  end

endmodule

### bench/position_reply_line_parser_tb.sv
// Testbench top for the position reply line parser.
// Drives reply lines with bursty timing, stalls the result side, gives the verdict.
// Depends on rpl_pkg, rpl_byte_if, rpl_result_if, rpl_line_checker and the block.
module position_reply_line_parser_tb;
  import rpl_pkg::*;

  localparam int LINE_CAP     = LineCapDefault;
  localparam int RANDOM_BYTES = 1650;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;

  logic clk_i;
  logic rst_ni;

  rpl_byte_if   rx_ch ();
  rpl_result_if res_ch ();

  int fail_count;
  int pending;

  // Set once by the stimulus to ask the result side for one long hold-off.
  bit hold_req = 1'b0;
  // Bytes left in the current sender burst, and bytes counted toward the run length.
  int burst_left = 0;
  int sent_count = 0;

  position_reply_line_parser #(
    .LINE_CAP(LINE_CAP)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_ch),
    .res_o (res_ch)
  );

  rpl_line_checker #(
    .LINE_CAP(LINE_CAP)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_mon      (rx_ch),
    .res_mon     (res_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // A run that stalls forever, or leaves a report that never arrives, ends here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("position_reply_line_parser verification failed");
        $finish;
      end
    end
  end

  // Result side. It works through segments of random length, each with its own
  // stall pattern: always ready, coin flip, every fourth tick, or mostly stalled.
  // When the stimulus asks, it holds ready low for a long counted stretch so that
  // both internal registers fill and the byte input stalls.
  initial begin : result_side
    int mode;
    int span;
    int tick;
    bit hold_taken;
    res_ch.ready <= 1'b0;
    tick = 0;
    hold_taken = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        if (hold_req && !hold_taken) begin
          hold_taken = 1'b1;
          res_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end else begin
          case (mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            2:       res_ch.ready <= (tick % 4 == 0);
            default: res_ch.ready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  // Offers one byte and returns at the clock edge that accepts it. Bytes go out
  // in bursts, and the sender may idle before a new burst. Ready is
  // looked at on the falling edge, when every input has settled.
  task automatic send_byte(input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= ch;
    forever begin
      @(negedge clk_i);
      if (rx_ch.ready === 1'b1) break;
    end
    @(posedge clk_i);
    burst_left--;
    if (ch != ChCr) sent_count++;
  endtask

  // Now and then a carriage return slips in ahead of a byte; the block drops it.
  task automatic send_char(input logic [7:0] ch);
    if ($urandom_range(0, 29) == 0) send_byte(ChCr);
    send_byte(ch);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Stops offering bytes until every predicted report has been taken.
  task automatic wait_for_replies();
    rx_ch.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
    burst_left = 0;
  endtask

  function automatic logic [7:0] blank_char();
    logic [7:0] ch;
    case ($urandom_range(0, 3))
      0:       ch = ChSpace;
      1:       ch = ChTab;
      2:       ch = ChVt;
      default: ch = ChFf;
    endcase
    return ch;
  endfunction

  // Filler biased toward keyword letters, digits and blanks so that partial
  // keyword matches and restarts on a stray 'E' happen often. Never a newline.
  function automatic logic [7:0] noise_char(input bit allow_nul);
    string kw;
    logic [7:0] ch;
    kw = "EPOS=";
    case ($urandom_range(0, 7))
      0, 1:    ch = kw[$urandom_range(0, 4)];
      2:       ch = ChZero + 8'($urandom_range(0, 9));
      3:       ch = blank_char();
      default: ch = 8'($urandom_range(0, 255));
    endcase
    if (ch == ChLf || (ch == ChNul && !allow_nul)) ch = ChUpE;
    return ch;
  endfunction

  // Digit strings: none at all, values at and just past the 32-bit signed
  // limits, long runs that saturate, leading zeros, and plain random values.
  function automatic string digit_text();
    string s;
    case ($urandom_range(0, 9))
      0:       s = "";
      1:       s = "2147483647";
      2:       s = "2147483648";
      3:       s = "2147483649";
      4:       s = $sformatf("%0d%0d", $urandom_range(1, 9999), $urandom);
      5:       s = $sformatf("000%0d", $urandom_range(0, 999));
      6, 7:    s = $sformatf("%0d", $urandom);
      default: s = $sformatf("%0d", $urandom_range(0, 99999));
    endcase
    return s;
  endfunction

  // A well-formed reply: some leading text, the keyword, optional blanks and
  // sign, digits, then a tail that may hold a zero byte, a second keyword
  // (which must be ignored) or more filler.
  task automatic send_position_line();
    int n;
    n = $urandom_range(0, 6);
    repeat (n) send_char(noise_char(1'b0));
    send_text("EPOS=");
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) send_char(blank_char());
    case ($urandom_range(0, 3))
      0:       send_char(ChPlus);
      1:       send_char(ChMinus);
      default: begin
      end
    endcase
    send_text(digit_text());
    case ($urandom_range(0, 5))
      0: begin
        send_byte(ChNul);
        send_text("77");
      end
      1:       send_text("EPOS=31");
      2:       repeat ($urandom_range(1, 4)) send_char(noise_char(1'b1));
      default: begin
      end
    endcase
    send_char(ChLf);
  endtask

  // Near misses of the keyword, a zero byte inside it, or plain filler.
  task automatic send_broken_line();
    case ($urandom_range(0, 4))
      0:       send_text("EPO=1");
      1:       send_text("EPOS 5");
      2:       send_text("epos=9");
      3: begin
        send_text("EP");
        send_byte(ChNul);
        send_text("OS=3");
      end
      default: repeat ($urandom_range(1, 12)) send_char(noise_char(1'b1));
    endcase
    send_char(ChLf);
  endtask

  // Lowercase filler puts the keyword close to the line capacity, so the cap
  // cuts into the keyword or the number, or just misses it.
  task automatic send_long_line();
    int lead;
    lead = $urandom_range(LINE_CAP - 14, LINE_CAP + 2);
    repeat (lead) send_char(8'($urandom_range(8'h61, 8'h7A)));
    send_text("EPOS=-123456789");
    repeat ($urandom_range(0, 10)) send_char(8'h61);
    send_char(ChLf);
  endtask

  // Raw bytes over the whole range; a newline among them just splits the line.
  task automatic send_raw_line();
    repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
    send_char(ChLf);
  endtask

  initial begin : stimulus
    int  pick;
    bit  hold_done;
    bit  drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    rst_ni        <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines: zero, both ends of the signed range, saturation either way,
    // keyword with no number or only a sign, empty lines with and without a
    // carriage return, blanks after the keyword, a line dead from a zero byte
    // before the keyword, a number cut short by a zero byte, and byte 0xFF.
    send_text("EPOS=0\n");
    send_text("EPOS=2147483647\n");
    send_text("EPOS=-2147483648\n");
    send_text("EPOS=99999999999\n");
    send_text("EPOS=-99999999999\n");
    send_text("EPOS=\n");
    send_text("\n");
    send_text("\r\n");
    send_text("xEEPOS=\t\v\f -42\n");
    send_text("A");
    send_byte(ChNul);
    send_text("EPOS=5\n");
    send_text("EPOS=12");
    send_byte(ChNul);
    send_text("9\n");
    send_byte(8'hFF);
    send_text("EPOS=+\n");
    wait_for_replies();

    // Random lines, mostly well-formed replies with random content.
    while (sent_count < RANDOM_BYTES) begin
      if (!hold_done && sent_count >= RANDOM_BYTES / 3) begin
        // Short replies keep coming while the result side holds off, so the
        // block backs up and must stall its byte input.
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (12) send_text($sformatf("EPOS=%0d\n", $urandom_range(0, 500)));
      end
      if (!drain_done && sent_count >= 2 * RANDOM_BYTES / 3) begin
        drain_done = 1'b1;
        wait_for_replies();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) send_position_line();
      else if (pick < 68) send_long_line();
      else if (pick < 86) send_broken_line();
      else if (pick < 93) send_char(ChLf);
      else send_raw_line();
    end

    // Let the last reports drain, then wait for anything stray before the verdict.
    wait_for_replies();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("position_reply_line_parser verification clean");
    end else begin
      $display("position_reply_line_parser verification failed");
    end
    $finish;
  end

endmodule
